// File: hdl/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

    // Sizes of the elapsed-time and cycle counters
    localparam int TIME_BITS  = 24;
    localparam int COUNT_BITS = 16;

    // Field widths
    localparam int ACT_W  = 2;
    localparam int DT_W   = 16;
    localparam int DUR_W  = 24;
    localparam int LIM_W  = 17;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    // Widths used for exact compares and saturating sums
    localparam int TCMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
    localparam int SUM_W  = ((TIME_BITS > DT_W) ? TIME_BITS : DT_W) + 1;
    localparam int CCMP_W = (COUNT_BITS > LIM_W - 1) ? COUNT_BITS : LIM_W - 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_PLAY  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        REG_START_HIDDEN = 3'd0,
        REG_HOLD_TICKS   = 3'd1,
        REG_VISIBLE      = 3'd2,
        REG_HIDDEN       = 3'd3,
        REG_CYCLE_LIMIT  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                  running;
        logic                  in_hold;
        logic                  shown;
        logic                  done;
        logic [COUNT_BITS-1:0] cyc;
        logic [TIME_BITS-1:0]  pe;
    } t_seq_state;

endpackage

`default_nettype wire

// File: hdl/bsc_if.sv
`default_nettype none

interface bsc_in_if;
    import bsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [DT_W-1:0]   elapsed_ticks;

    modport source (output valid, output action, output elapsed_ticks, input ready);
    modport sink   (input valid, input action, input elapsed_ticks, output ready);
endinterface

interface bsc_out_if;
    logic valid;
    logic ready;
    logic visible;
    logic playing;
    logic done_res;

    modport source (output valid, output visible, output playing, output done_res,
                    input ready);
    modport sink   (input valid, input visible, input playing, input done_res,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/blink_sequence_controller_top.sv
// The result item is registered: it enters the output register, or the skid entry while that register is full.
// Throughput: one item per cycle while i_cmd.ready is high; the state update is one pass of compare/add logic.
// i_cmd drops ready only while both output entries (main register and skid) hold results,
//   so a single result waiting downstream does not stall the input.
// Reset (i_rst_n low, synchronous): idle, visible, counters cleared, registers
//   back to zero, output stage empty.
`default_nettype none

module blink_sequence_controller_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    bsc_in_if.sink                    i_cmd,
    bsc_out_if.source                 o_res,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire [bsc_pkg::ADDR_W-1:0] paddr,
    input  wire [bsc_pkg::DATA_W-1:0] pwdata,
    output logic [bsc_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);
    import bsc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                     r_start_hidden;
    logic [DUR_W-1:0]         r_hold_ticks;
    logic [DUR_W-1:0]         r_visible_ticks;
    logic [DUR_W-1:0]         r_hidden_ticks;
    logic signed [LIM_W-1:0]  r_cycle_limit;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_hidden  <= 1'b0;
            r_hold_ticks    <= '0;
            r_visible_ticks <= '0;
            r_hidden_ticks  <= '0;
            r_cycle_limit   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_START_HIDDEN: r_start_hidden  <= pwdata[0];
                REG_HOLD_TICKS:   r_hold_ticks    <= pwdata[DUR_W-1:0];
                REG_VISIBLE:      r_visible_ticks <= pwdata[DUR_W-1:0];
                REG_HIDDEN:       r_hidden_ticks  <= pwdata[DUR_W-1:0];
                REG_CYCLE_LIMIT:  r_cycle_limit   <= pwdata[LIM_W-1:0];
                default: ;        // unmapped addresses ignore writes
            endcase
        end
    end

    // Read-back; cycle_limit comes back sign-extended
    always_comb begin
        unique case (cfg_idx)
            REG_START_HIDDEN: prdata = {{(DATA_W-1){1'b0}}, r_start_hidden};
            REG_HOLD_TICKS:   prdata = DATA_W'(r_hold_ticks);
            REG_VISIBLE:      prdata = DATA_W'(r_visible_ticks);
            REG_HIDDEN:       prdata = DATA_W'(r_hidden_ticks);
            REG_CYCLE_LIMIT:  prdata = {{(DATA_W-LIM_W){r_cycle_limit[LIM_W-1]}},
                                        r_cycle_limit};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Derived controls
    // ------------------------------------------------------------------
    logic              start_lvl;    // level shown on play
    logic              lim_nonneg;   // counting enabled
    logic [CCMP_W-1:0] lim_ext;      // nonnegative limit, compare width
    logic              lim_fits;     // limit reachable by the saturating count

    assign start_lvl  = ~r_start_hidden;
    assign lim_nonneg = ~r_cycle_limit[LIM_W-1];
    assign lim_ext    = CCMP_W'(r_cycle_limit[LIM_W-2:0]);
    assign lim_fits   = lim_ext <= CCMP_W'({COUNT_BITS{1'b1}});

    // ------------------------------------------------------------------
    // Sequencer step functions
    // ------------------------------------------------------------------
    function automatic t_seq_state f_finish(t_seq_state s);
        t_seq_state r;
        r         = s;
        r.running = 1'b0;
        r.in_hold = 1'b0;
        r.pe      = '0;
        r.done    = 1'b1;
        return r;
    endfunction

    // Phase end: flip the level; leave hold without counting, else count a
    // return to the start level.
    function automatic t_seq_state f_flip(t_seq_state s);
        t_seq_state r;
        r       = s;
        r.shown = ~s.shown;
        if (s.in_hold) begin
            r.in_hold = 1'b0;
        end else if ((r.shown == start_lvl) && lim_nonneg) begin
            if (r.cyc != {COUNT_BITS{1'b1}})
                r.cyc = r.cyc + COUNT_BITS'(1);
            if (CCMP_W'(r.cyc) >= lim_ext)
                r = f_finish(r);
        end
        return r;
    endfunction

    // Skip zero-length phases. At most one flip is needed: the phase after
    // it has nonzero length, or both are zero and the run ends here.
    function automatic t_seq_state f_settle(t_seq_state s);
        t_seq_state       r;
        logic [DUR_W-1:0] cur;
        logic [DUR_W-1:0] other;
        r     = s;
        cur   = s.shown ? r_visible_ticks : r_hidden_ticks;
        other = s.shown ? r_hidden_ticks  : r_visible_ticks;
        if (s.running) begin
            if (cur != '0) begin
                r.pe = '0;
            end else if (other == '0) begin
                // cannot blink: jump to the limit if it is reachable
                if (lim_nonneg && lim_fits) begin
                    r.shown = start_lvl;
                    if (CCMP_W'(r.cyc) < lim_ext)
                        r.cyc = COUNT_BITS'(lim_ext);
                end
                r = f_finish(r);
            end else begin
                r    = f_flip(r);
                r.pe = '0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sequencer state and next-state logic
    // ------------------------------------------------------------------
    t_seq_state       r_st;
    t_seq_state       n_st;
    logic [SUM_W-1:0] pe_sum;
    logic [DUR_W-1:0] target;
    logic             in_fire;

    always_comb begin
        n_st      = r_st;
        n_st.done = 1'b0;
        pe_sum    = SUM_W'(r_st.pe) + SUM_W'(i_cmd.elapsed_ticks);
        target    = r_st.in_hold ? r_hold_ticks
                  : (r_st.shown ? r_visible_ticks : r_hidden_ticks);
        case (i_cmd.action)
            ACT_PLAY: begin
                n_st.running = 1'b1;
                n_st.cyc     = '0;
                n_st.in_hold = (r_hold_ticks != '0);
                n_st.shown   = start_lvl;
                n_st.pe      = '0;
                if (r_cycle_limit == '0)
                    n_st = f_finish(n_st);
                else if (!n_st.in_hold)
                    n_st = f_settle(n_st);
            end
            ACT_CLEAR: begin
                n_st.running = 1'b0;
                n_st.in_hold = 1'b0;
                n_st.shown   = 1'b1;
                n_st.cyc     = '0;
                n_st.pe      = '0;
            end
            ACT_TICK: begin
                if (r_st.running) begin
                    // saturating elapsed time; overshoot is dropped on flip
                    if (pe_sum > SUM_W'({TIME_BITS{1'b1}}))
                        n_st.pe = {TIME_BITS{1'b1}};
                    else
                        n_st.pe = pe_sum[TIME_BITS-1:0];
                    if (TCMP_W'(n_st.pe) >= TCMP_W'(target))
                        n_st = f_settle(f_flip(n_st));
                end
            end
            default: ;   // unused code: report current state
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.running <= 1'b0;
            r_st.in_hold <= 1'b0;
            r_st.shown   <= 1'b1;
            r_st.done    <= 1'b0;
            r_st.cyc     <= '0;
            r_st.pe      <= '0;
        end else if (in_fire) begin
            r_st <= n_st;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: main register plus skid entry
    // ------------------------------------------------------------------
    logic       r_out_vld;
    logic       r_skid_vld;
    logic [2:0] r_out_data;    // {visible, playing, done}
    logic [2:0] r_skid_data;
    logic [2:0] res_data;
    logic       out_fire;

    assign i_cmd.ready = ~r_skid_vld;
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign out_fire    = r_out_vld && o_res.ready;
    assign res_data    = {n_st.shown, n_st.running, n_st.done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (out_fire) begin
                if (r_skid_vld) begin
                    r_out_data <= r_skid_data;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= in_fire;
                    if (in_fire)
                        r_out_data <= res_data;
                end
            end else if (in_fire) begin
                if (!r_out_vld) begin
                    r_out_vld  <= 1'b1;
                    r_out_data <= res_data;
                end else begin
                    r_skid_vld  <= 1'b1;
                    r_skid_data <= res_data;
                end
            end
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.visible  = r_out_data[2];
    assign o_res.playing  = r_out_data[1];
    assign o_res.done_res = r_out_data[0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held while output register empty");

    a_done_not_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.done_res) |-> !o_res.playing)
        else $error("done result still reports playing");

    a_hold_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.in_hold |-> r_st.running)
        else $error("hold phase while idle");

    a_idle_time_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.running |-> (r_st.pe == '0))
        else $error("elapsed time nonzero while idle");

endmodule

`default_nettype wire
